// ----- rtl/pidt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_pkg - shared types and constants of the trapezoidal PID controller
// Register indexes, fixed field widths, sequencer states and the control
// word of the serial multiplier.
// ----------------------------------------------------------------------------
package pidt_pkg;

  // Fixed field widths
  localparam int GAIN_W      = 32;          // Q16.16 gains
  localparam int PERIOD_W    = 32;          // Q0.32 sample period
  localparam int LIMIT_W     = 31;          // Q16.16 magnitude bound
  localparam int MUL_Y_W     = GAIN_W + 1;  // multiplier operand with sign slot
  localparam int ROUND_SHIFT = 16;          // Q.32 sum back to Q16.16
  localparam int INC_SHIFT   = 33;          // period scaling plus the halving

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_INT_MUL,
    ST_P_MUL,
    ST_I_MUL,
    ST_D_MUL,
    ST_ROUND,
    ST_CLAMP
  } pidt_state_e;

  // Control word into the serial multiplier
  typedef struct packed {
    logic start;
    logic y_signed;
  } mul_ctrl_t;

endpackage

// ----- rtl/pid_trapezoidal_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_trapezoidal_controller - discrete PID with trapezoidal integration
// One drive value per measurement/setpoint word, all in signed Q16.16.
// The four products run one after another on a shared bit-serial multiplier.
//
//   channel   dir  handshake                 payload
//   s_axis    in   tvalid/tready             tdata: measured, target
//   m_axis    out  tvalid/tready             tdata: drive; tuser: saturated
//   cfg       in   cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// A word passes from acceptance to the next acceptance through setup, four
// products of 33 serial multiplier steps plus a hand-off each, round, clamp
// and the idle state that takes the next word, so no new word is taken while
// one is in flight. The multiplier's 33-step loop takes most of that time.
// Reset clears the gains and period, sets the bound to its maximum and marks
// the first sample pending. The result sits in an output register, so a
// stalled m_axis only holds the clamp step once the next word is done.
// ----------------------------------------------------------------------------
module pid_trapezoidal_controller #(
  parameter int DATA_WIDTH  = 32,
  parameter int INTEG_WIDTH = 48
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // tdata: [DATA_WIDTH-1:0] measured_value, [2*DATA_WIDTH-1:DATA_WIDTH] target_value
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  // tdata: [DATA_WIDTH-1:0] drive_value
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]          m_axis_tdata,
  // tuser: [0] drive_saturated
  output logic [0:0]                               m_axis_tuser,
  input  logic                                     cfg_we_i,
  input  logic [pidt_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [pidt_pkg::CFG_DATA_W-1:0]          cfg_data_i
);
  import pidt_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int IW    = INTEG_WIDTH;
  localparam int EW    = DW + 1;                       // error
  localparam int SW    = DW + 2;                       // error sum / difference
  localparam int XW    = (IW > DW + 3) ? IW : DW + 3;  // multiplicand
  localparam int PW    = XW + MUL_Y_W;                 // product
  localparam int AW    = PW + 2;                       // sum of three products
  localparam int RW    = AW - ROUND_SHIFT;             // rounded sum
  localparam int IMW   = DW + 1;                       // increment magnitude
  localparam int SUMW  = ((IW > SW) ? IW : SW) + 1;    // integral update
  localparam int OUT_W = ((DW + 7) / 8) * 8;

  // Configuration registers
  logic signed [GAIN_W-1:0] prop_gain_q;
  logic signed [GAIN_W-1:0] integ_gain_q;
  logic signed [GAIN_W-1:0] deriv_gain_q;
  logic [LIMIT_W-1:0]       drive_limit_q;
  logic [PERIOD_W-1:0]      sample_period_q;

  // Sequencer
  pidt_state_e state_q, state_d;
  mul_ctrl_t   mul_ctrl;
  logic        mul_done;
  logic signed [PW-1:0] mul_prod;
  logic signed [XW-1:0] mul_x;
  logic [GAIN_W-1:0]    mul_y;

  logic in_fire, acc_clear, int_upd, acc_add, do_round, clamp_fire;

  // Sample state
  logic                 started_q;
  logic                 first_q;
  logic signed [EW-1:0] e_q;
  logic signed [EW-1:0] last_q;
  logic [SW-1:0]        s_abs_q;
  logic                 s_neg_q;
  logic signed [SW-1:0] diff_q;
  logic signed [IW-1:0] integ_q;
  logic signed [AW-1:0] acc_q;

  // Output register
  logic          out_valid_q;
  logic [DW-1:0] out_drive_q;
  logic          out_sat_q;

  // --------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q     <= '0;
      integ_gain_q    <= '0;
      deriv_gain_q    <= '0;
      drive_limit_q   <= LIMIT_RESET;
      sample_period_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PROP_GAIN:     prop_gain_q     <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN:    integ_gain_q    <= cfg_data_i[GAIN_W-1:0];
        REG_DERIV_GAIN:    deriv_gain_q    <= cfg_data_i[GAIN_W-1:0];
        REG_DRIVE_LIMIT:   drive_limit_q   <= cfg_data_i[LIMIT_W-1:0];
        REG_SAMPLE_PERIOD: sample_period_q <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (s_axis_tvalid) state_d = ST_SETUP;
      ST_SETUP:   state_d = ST_INT_MUL;
      ST_INT_MUL: if (mul_done) state_d = ST_P_MUL;
      ST_P_MUL:   if (mul_done) state_d = ST_I_MUL;
      ST_I_MUL:   if (mul_done) state_d = ST_D_MUL;
      ST_D_MUL:   if (mul_done) state_d = ST_ROUND;
      ST_ROUND:   state_d = ST_CLAMP;
      ST_CLAMP:   if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer: strobes
  always_comb begin
    s_axis_tready = 1'b0;
    mul_ctrl      = '0;
    acc_clear     = 1'b0;
    int_upd       = 1'b0;
    acc_add       = 1'b0;
    do_round      = 1'b0;
    clamp_fire    = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_SETUP: begin
        mul_ctrl.start = 1'b1;
        acc_clear      = 1'b1;
      end
      ST_INT_MUL: begin
        int_upd           = mul_done;
        mul_ctrl.start    = mul_done;
        mul_ctrl.y_signed = 1'b1;
      end
      ST_P_MUL, ST_I_MUL: begin
        acc_add           = mul_done;
        mul_ctrl.start    = mul_done;
        mul_ctrl.y_signed = 1'b1;
      end
      ST_D_MUL: acc_add = mul_done;
      ST_ROUND: do_round = 1'b1;
      ST_CLAMP: clamp_fire = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign in_fire = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Multiplier operands, picked by the product being started
  always_comb begin
    unique case (state_q)
      ST_SETUP: begin
        mul_x = XW'(s_abs_q);
        mul_y = sample_period_q;
      end
      ST_P_MUL: begin
        mul_x = XW'(integ_q);
        mul_y = integ_gain_q;
      end
      ST_I_MUL: begin
        mul_x = XW'(diff_q);
        mul_y = deriv_gain_q;
      end
      default: begin
        mul_x = XW'(e_q);
        mul_y = prop_gain_q;
      end
    endcase
  end

  pidt_serial_mult #(
    .XW (XW)
  ) u_mult (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // --------------------------------------------------------------------------
  // Error, error sum and difference of a new word
  logic signed [DW-1:0] meas, targ;
  logic signed [EW-1:0] e_new;
  logic signed [SW-1:0] s_new, diff_new, s_negated;

  always_comb begin
    meas      = s_axis_tdata[DW-1:0];
    targ      = s_axis_tdata[2*DW-1:DW];
    e_new     = EW'(targ) - EW'(meas);
    s_new     = SW'(e_new) + SW'(last_q);
    diff_new  = SW'(e_new) - SW'(last_q);
    s_negated = -s_new;
  end

  // Rounded integration step and saturating integral update
  logic [PW:0]            inc_round;
  logic [IMW-1:0]         inc_mag;
  logic signed [SW-1:0]   inc;
  logic signed [SUMW-1:0] integ_sum;
  logic                   integ_hi, integ_lo;
  logic signed [IW-1:0]   integ_next;

  always_comb begin
    inc_round  = {1'b0, mul_prod} + ((PW+1)'(1) << (INC_SHIFT - 1));
    inc_mag    = inc_round[INC_SHIFT +: IMW];
    inc        = s_neg_q ? -SW'(inc_mag) : SW'(inc_mag);
    integ_sum  = SUMW'(integ_q) + SUMW'(inc);
    integ_hi   = !integ_sum[SUMW-1] && (integ_sum[SUMW-2:IW-1] != '0);
    integ_lo   = integ_sum[SUMW-1] && (integ_sum[SUMW-2:IW-1] != '1);
    if (integ_hi) begin
      integ_next = {1'b0, {(IW-1){1'b1}}};
    end else if (integ_lo) begin
      integ_next = {1'b1, {(IW-1){1'b0}}};
    end else begin
      integ_next = integ_sum[IW-1:0];
    end
  end

  // Hold the first-sample flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
    end else if (in_fire) begin
      started_q <= 1'b1;
    end
  end

  // Sample registers and accumulator
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      e_q     <= e_new;
      last_q  <= e_new;
      first_q <= !started_q;
      s_neg_q <= s_new[SW-1];
      s_abs_q <= s_new[SW-1] ? s_negated : s_new;
      diff_q  <= started_q ? diff_new : '0;
      if (!started_q) begin
        integ_q <= '0;
      end
    end
    if (int_upd && !first_q) begin
      integ_q <= integ_next;
    end
    priority if (acc_clear) begin
      acc_q <= '0;
    end else if (acc_add) begin
      acc_q <= acc_q + AW'(mul_prod);
    end else if (do_round) begin
      acc_q <= acc_q + (AW'(1) << (ROUND_SHIFT - 1));
    end
  end

  // --------------------------------------------------------------------------
  // Clamp the rounded sum to +/- bound
  logic signed [RW-1:0] rnd;
  logic signed [RW-1:0] lim;
  logic signed [RW:0]   margin;
  logic                 rnd_neg, sat;
  logic signed [RW-1:0] res;

  always_comb begin
    rnd     = acc_q[AW-1:ROUND_SHIFT];
    lim     = RW'({1'b0, drive_limit_q});
    rnd_neg = rnd[RW-1];
    margin  = rnd_neg ? ((RW+1)'(rnd) + (RW+1)'(lim)) : ((RW+1)'(rnd) - (RW+1)'(lim));
    sat     = rnd_neg ? margin[RW] : (!margin[RW] && (margin != '0));
    if (!sat) begin
      res = rnd;
    end else if (rnd_neg) begin
      res = -lim;
    end else begin
      res = lim;
    end
  end

  // Output register: load on clamp, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (clamp_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clamp_fire) begin
      out_drive_q <= res[DW-1:0];
      out_sat_q   <= sat;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = OUT_W'(out_drive_q);
  assign m_axis_tuser[0] = out_sat_q;

endmodule

// ----- rtl/pidt_serial_mult.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidt_serial_mult - bit-serial signed multiplier
// Retires one multiplier bit per cycle: the partial product shifts right
// through hi/lo while the multiplier bits shift out of lo. The top multiplier
// bit carries negative weight when the operand is signed.
// ----------------------------------------------------------------------------
module pidt_serial_mult #(
  parameter int XW = 51
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  pidt_pkg::mul_ctrl_t                   ctrl_i,
  input  logic signed [XW-1:0]                  x_i,
  input  logic [pidt_pkg::GAIN_W-1:0]           y_i,
  output logic                                  done_o,
  output logic signed [XW+pidt_pkg::MUL_Y_W-1:0] prod_o
);
  import pidt_pkg::*;

  localparam int CNT_W = $clog2(MUL_Y_W);

  logic signed [XW:0]   hi_q;
  logic [MUL_Y_W-1:0]   lo_q;
  logic signed [XW-1:0] x_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic                 last_step;
  logic signed [XW+1:0] x_ext;
  logic signed [XW+1:0] addend;
  logic signed [XW+1:0] sum;
  logic [MUL_Y_W-1:0]   y_ext;

  // Add (or on the sign bit subtract) the multiplicand, then shift
  always_comb begin
    last_step = (cnt_q == CNT_W'(MUL_Y_W - 1));
    x_ext     = (XW+2)'(x_q);
    if (!lo_q[0]) begin
      addend = '0;
    end else if (last_step) begin
      addend = -x_ext;
    end else begin
      addend = x_ext;
    end
    sum   = (XW+2)'(hi_q) + addend;
    y_ext = {ctrl_i.y_signed & y_i[GAIN_W-1], y_i};
  end

  // Step counter and handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial product and shifting multiplier
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      hi_q <= '0;
      lo_q <= y_ext;
      x_q  <= x_i;
    end else if (busy_q) begin
      hi_q <= sum[XW+1:1];
      lo_q <= {sum[0], lo_q[MUL_Y_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q[XW-1:0], lo_q};

endmodule

// ----- tb/sv/tb_pid_trapezoidal_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_trapezoidal_controller - self-checking bench for the trapezoidal PID
// Sends measurement/setpoint words with random sender gaps and output stalls.
// A fixed-point predictor runs next to the block and every drive word that
// comes back is compared, value and saturation flag, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_pid_trapezoidal_controller;
  import pidt_pkg::*;

  localparam int     DW          = 32;
  localparam int     IW          = 48;
  localparam longint INTEG_MAX   = (64'sd1 <<< (IW - 1)) - 1;
  localparam longint INTEG_MIN   = -INTEG_MAX - 1;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 32'h0001_0000;
  localparam logic [GAIN_W-1:0] GAIN_MIN = 32'h8000_0000;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 32'h7FFF_FFFF;
  localparam int     DRAIN_WAIT  = 150;

  typedef struct packed {
    logic [DW-1:0] drive;
    logic          sat;
  } drive_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [2*DW-1:0]       s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [DW-1:0]         m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Settings as the block should hold them
  logic signed [GAIN_W-1:0] kp = '0;
  logic signed [GAIN_W-1:0] ki = '0;
  logic signed [GAIN_W-1:0] kd = '0;
  logic [LIMIT_W-1:0]       drive_bound = LIMIT_RESET;
  logic [PERIOD_W-1:0]      period = '0;

  // Controller state
  bit                 started  = 1'b0;
  logic signed [DW:0] prev_err = '0;
  longint             integ    = 0;

  drive_word_t        pending_drives[$];
  int                 mismatches = 0;
  bit                 idle_en    = 1'b1;
  logic [DW-1:0]      setpoint   = '0;

  pid_trapezoidal_controller #(
    .DATA_WIDTH  (DW),
    .INTEG_WIDTH (IW)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Advance the controller state by one sample and queue the drive word
  task automatic compute_drive(input logic [DW-1:0] meas, input logic [DW-1:0] targ);
    logic signed [DW+1:0] err;
    logic signed [DW+1:0] err_sum;
    logic signed [DW+1:0] err_diff;
    logic [DW+1:0]        sum_mag;
    logic [127:0]         scaled;
    longint               inc;
    longint               next_integ;
    logic signed [127:0]  acc;
    logic signed [127:0]  bound;
    logic signed [127:0]  q;
    drive_word_t          word;
    err = $signed({{2{targ[DW-1]}}, targ}) - $signed({{2{meas[DW-1]}}, meas});
    err_diff = '0;
    if (!started) begin
      // first sample: no integral, no difference, just remember the error
      integ    = 0;
      prev_err = err[DW:0];
      started  = 1'b1;
    end else begin
      // trapezoid: (e + e_prev) * T / 2, magnitude rounded half away from zero
      err_sum = err + prev_err;
      sum_mag = (err_sum < 0) ? -err_sum : err_sum;
      scaled  = 128'(sum_mag) * 128'(period) + (128'd1 << (INC_SHIFT - 1));
      inc     = longint'(scaled >> INC_SHIFT);
      if (err_sum < 0) inc = -inc;
      next_integ = integ + inc;
      if (next_integ > INTEG_MAX) next_integ = INTEG_MAX;
      else if (next_integ < INTEG_MIN) next_integ = INTEG_MIN;
      integ    = next_integ;
      err_diff = err - prev_err;
      prev_err = err[DW:0];
    end
    // exact Q.32 sum, round half up to Q16.16, clamp to the symmetric bound
    acc   = kp * err + ki * integ + kd * err_diff + (128'sd1 <<< (ROUND_SHIFT - 1));
    q     = acc >>> ROUND_SHIFT;
    bound = $signed(128'(drive_bound));
    word.sat = 1'b1;
    if (q > bound) q = bound;
    else if (q < -bound) q = -bound;
    else word.sat = 1'b0;
    word.drive = q[DW-1:0];
    pending_drives.push_back(word);
  endtask

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_PROP_GAIN:     kp = value;
      REG_INTEG_GAIN:    ki = value;
      REG_DERIV_GAIN:    kd = value;
      REG_DRIVE_LIMIT:   drive_bound = value[LIMIT_W-1:0];
      REG_SAMPLE_PERIOD: period = value;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] p_gain,
                               input logic [CFG_DATA_W-1:0] i_gain,
                               input logic [CFG_DATA_W-1:0] d_gain,
                               input logic [CFG_DATA_W-1:0] bound,
                               input logic [CFG_DATA_W-1:0] t_sample);
    write_reg(REG_PROP_GAIN, p_gain);
    write_reg(REG_INTEG_GAIN, i_gain);
    write_reg(REG_DERIV_GAIN, d_gain);
    write_reg(REG_DRIVE_LIMIT, bound);
    write_reg(REG_SAMPLE_PERIOD, t_sample);
  endtask

  // Offer one word, hold valid until accepted, then predict its drive word
  task automatic send_sample(input logic [DW-1:0] meas, input logic [DW-1:0] targ);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tdata  <= {targ, meas};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    compute_drive(meas, targ);
  endtask

  // Drop valid and wait until every predicted drive word has come back
  task automatic drain_drives();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [DW-1:0] pick_edge();
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    logic [GAIN_W-1:0] g;
    g = $urandom_range(0, 32'h0004_0000);
    case ($urandom_range(0, 7))
      0:       return GAIN_MIN;
      1:       return GAIN_MAX;
      2:       return '0;
      3, 4:    return $urandom_range(0, 1) ? -g : g;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_bound();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 32'h0010_0000);
      default: return $urandom_range(0, 32'h7FFF_FFFF);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_period();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Setpoint held for stretches, measurement tracking it with noise
  task automatic run_samples(input int count);
    logic [DW-1:0] meas;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 15))
        0:       setpoint = $urandom;
        1:       setpoint = pick_edge();
        2:       setpoint = $urandom_range(0, 32'h000F_FFFF);
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0:       meas = $urandom;
        1:       meas = pick_edge();
        default: meas = setpoint + ($urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000);
      endcase
      send_sample(meas, setpoint);
    end
  endtask

  // First sample after reset: only the proportional path may count
  task automatic test_first_sample();
    load_settings(32'h0002_0000, GAIN_MAX, GAIN_MAX, 32'h7FFF_FFFF, '1);
    send_sample(32'h0001_0000, 32'h0004_0000);
    drain_drives();
  endtask

  // Full-scale and alternating-bit measurements and setpoints
  task automatic test_field_extremes();
    load_settings(GAIN_ONE, GAIN_MIN, GAIN_MAX, 32'h7FFF_FFFF, '1);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000);
    send_sample(32'h5555_5555, 32'hAAAA_AAAA);
    send_sample(32'hAAAA_AAAA, 32'h5555_5555);
    send_sample(32'h0000_0000, 32'hFFFF_FFFF);
    send_sample(32'h8000_0000, 32'h8000_0000);
    drain_drives();
  endtask

  // Results landing exactly on the bound, just past it, and a zero bound
  task automatic test_bound_cases();
    load_settings(GAIN_ONE, '0, '0, 32'h0001_0000, '0);
    send_sample('0, 32'h0001_0000);
    send_sample('0, 32'h0001_0001);
    send_sample('0, 32'hFFFF_0000);
    send_sample('0, 32'hFFFE_FFFF);
    drain_drives();
    write_reg(REG_DRIVE_LIMIT, '0);
    send_sample('0, '0);
    send_sample('0, 32'h0000_0005);
    send_sample('0, 32'hFFFF_FFFB);
    drain_drives();
  endtask

  // Writes to unused indexes are dropped, so are bound bits above its width
  task automatic test_register_index();
    load_settings(GAIN_ONE, 32'h0000_4000, 32'h0000_8000, 32'h7FFF_FFFF, 32'h0100_0000);
    for (int idx = int'(REG_SAMPLE_PERIOD) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), '1);
    end
    write_reg(REG_DRIVE_LIMIT, 32'hFFFF_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h0000_0000, 32'h7FFF_0000);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    drain_drives();
  endtask

  // Several settings in turn, the extremes first, random ones after
  task automatic test_random_control();
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       load_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, 32'h7FFF_FFFF, '1);
        1:       load_settings(GAIN_MIN, GAIN_MIN, GAIN_MIN, 32'h7FFF_FFFF, '1);
        2:       load_settings(GAIN_ONE, GAIN_ONE, GAIN_ONE, pick_bound(), pick_period());
        default: load_settings(pick_gain(), pick_gain(), pick_gain(), pick_bound(),
                               pick_period());
      endcase
      run_samples(220);
      drain_drives();
    end
  endtask

  // Back-to-back words with the output always ready
  task automatic test_no_idle();
    idle_en = 1'b0;
    load_settings(pick_gain(), pick_gain(), pick_gain(), pick_bound(), pick_period());
    run_samples(150);
    drain_drives();
  endtask

  // Output ready with random stall bursts
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Check each accepted drive word against the oldest prediction
  always @(posedge clk_i) begin : check_drives
    drive_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected drive word: expected none, actual %h sat %b",
                 $time, m_axis_tdata, m_axis_tuser[0]);
        mismatches++;
      end else begin
        want = pending_drives.pop_front();
        if (m_axis_tdata !== want.drive) begin
          $display("%0t: drive_value mismatch: expected %h, actual %h",
                   $time, want.drive, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser[0] !== want.sat) begin
          $display("%0t: drive_saturated mismatch: expected %b, actual %b",
                   $time, want.sat, m_axis_tuser[0]);
          mismatches++;
        end
      end
    end
  end

  // Hard stop well past the slowest correct run
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_first_sample();
    test_field_extremes();
    test_bound_cases();
    test_register_index();
    test_random_control();
    test_no_idle();

    // let any stray word show up before the verdict
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending_drives.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pidt_pkg.sv
rtl/pidt_serial_mult.sv
rtl/pid_trapezoidal_controller.sv
tb/sv/tb_pid_trapezoidal_controller.sv
